// ----- hw/rtl/gaussian_blur_3x3_core_defines.svh -----
// Assertion macros for the 3x3 blur core.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef GAUSSIAN_BLUR_3X3_CORE_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define GB3_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gb3 same-cycle check failed");
`define GB3_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gb3 next-cycle check failed");
`else
`define GB3_ASSERT_NOW(lbl, ante, cons)
`define GB3_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/gb3_pkg.sv -----
// Shared constants and types for the 3x3 blur core.
// No dependencies.
`default_nettype none

package gb3_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int PIX_W      = 8;
    localparam int CFG_W_BITS = 12;
    localparam int CFG_H_BITS = 13;
    localparam int ROW_BITS   = 13;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int WIN_TAPS   = 9;
    localparam int ACC_W      = 24;

    localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 13'd480;

    // register index, taken from paddr[2]
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Q0.16 kernel weights, sum 65536
    localparam logic [ACC_W-1:0] W_CORNER   = 24'd4922;
    localparam logic [ACC_W-1:0] W_EDGE     = 24'd8116;
    localparam logic [ACC_W-1:0] W_CENTRE   = 24'd13384;
    localparam logic [ACC_W-1:0] ROUND_HALF = 24'd32768;

    typedef struct packed {
        logic emit;   // this beat produces a result
        logic last;   // result ends the frame
        logic top;    // row above is inside the frame
        logic bot;    // row below is inside the frame
        logic lft;    // column left is inside the frame
        logic rgt;    // column right is inside the frame
    } gb3_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gb3_stream_if.sv -----
// Valid/ready stream interfaces for pixel input and blurred output.
// Depends on gb3_pkg.
`default_nettype none

interface gb3_pix_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [gb3_pkg::PIX_W-1:0]  pixel_in;

    modport source (output valid, output mode, output pixel_in, input ready);
    modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface gb3_pix_out_if;
    logic                       valid;
    logic                       ready;
    logic [gb3_pkg::PIX_W-1:0]  pixel_out;
    logic                       frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gb3_cfg.sv -----
// APB register file: image width and height, plus clamped effective sizes.
// Depends on gb3_pkg.
`default_nettype none

module gb3_cfg #(
    parameter int MAX_WIDTH  = gb3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gb3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gb3_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [gb3_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [gb3_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [$clog2(MAX_WIDTH+1)-1:0]      w_eff,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]     h_eff
);
    import gb3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [CFG_W_BITS-1:0] width_reg;
    logic [CFG_H_BITS-1:0] height_reg;
    logic                  wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_hit)
        begin
            unique case (paddr[2])
                REG_IDX_WIDTH:  width_reg  <= pwdata[CFG_W_BITS-1:0];
                REG_IDX_HEIGHT: height_reg <= pwdata[CFG_H_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_IDX_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IDX_HEIGHT: prdata = APB_DATA_W'(height_reg);
        endcase
    end

    // zero acts as one; oversize clamps to the line buffer depth (width) or to MAX_HEIGHT (height)
    always_comb
    begin
        if (width_reg == '0)
            w_eff = CW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(width_reg);

        if (height_reg == '0)
            h_eff = HW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gb3_pos.sv -----
// Stream position tracker: column/row of the incoming beat and border flags
// for the result it completes. Depends on gb3_pkg.
`default_nettype none
`include "gaussian_blur_3x3_core_defines.svh"

module gb3_pos #(
    parameter int MAX_WIDTH  = gb3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gb3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      w_eff,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     h_eff,
    output logic [$clog2(MAX_WIDTH)-1:0]        addr,
    output gb3_pkg::gb3_flags_t                 flags
);
    import gb3_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RCW = (HW > ROW_BITS) ? HW : ROW_BITS;

    logic [AW-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;

    logic                wrap_in, wrap_out;
    logic [AW-1:0]       col_cur;
    logic [ROW_BITS-1:0] row_cur;
    logic [CW-1:0]       col_inc, wm1, c_x;
    logic [ROW_BITS-1:0] res_row;
    logic [AW-1:0]       res_col;
    logic [RCW-1:0]      r_x, hm1_x;

    always_comb
    begin
        // a column beyond the width (width just shrunk) starts the next row
        wrap_in = CW'(col_reg) >= w_eff;
        col_cur = wrap_in ? '0 : col_reg;
        row_cur = wrap_in ? row_reg + ROW_BITS'(1) : row_reg;
        col_inc = CW'(col_cur) + CW'(1);
        wrap_out = col_inc >= w_eff;
        wm1 = w_eff - CW'(1);

        // result lags the input by one row and one pixel
        if (col_cur != '0)
        begin
            res_row = row_cur - ROW_BITS'(1);
            res_col = col_cur - AW'(1);
        end
        else
        begin
            res_row = row_cur - ROW_BITS'(2);
            res_col = AW'(wm1);
        end

        r_x   = RCW'(res_row);
        hm1_x = RCW'(h_eff - HW'(1));
        c_x   = CW'(res_col);

        flags.emit = !((row_cur == '0) || (row_cur == ROW_BITS'(1) && col_cur == '0));
        flags.last = flags.emit && ((r_x > hm1_x) || (r_x == hm1_x && c_x == wm1));
        flags.top  = res_row != '0;
        flags.bot  = r_x < hm1_x;
        flags.lft  = res_col != '0;
        flags.rgt  = c_x < wm1;

        if (flags.last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (wrap_out)
        begin
            col_next = '0;
            row_next = row_cur + ROW_BITS'(1);
        end
        else
        begin
            col_next = AW'(col_inc);
            row_next = row_cur;
        end
    end

    assign addr = col_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    `GB3_ASSERT_NEXT(a_pos_frame_restart, accept && flags.last, col_reg == '0 && row_reg == '0)

endmodule

`default_nettype wire

// ----- hw/rtl/gb3_linebuf.sv -----
// Two-row line buffer in one memory, one read and one write per cycle,
// with forwarding for a read of the address written on the same edge. Depends on gb3_pkg.
`default_nettype none

module gb3_linebuf #(
    parameter int MAX_WIDTH = gb3_pkg::DEF_MAX_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]    rd_addr,
    input  logic                            wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
    input  logic [gb3_pkg::PIX_W-1:0]       wr_pix,
    output logic [gb3_pkg::PIX_W-1:0]       above1,
    output logic [gb3_pkg::PIX_W-1:0]       above2
);
    import gb3_pkg::*;

    // entry = {two rows up, one row up}
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;
    logic [PIX_W-1:0]   fwd_up1_reg;
    logic [PIX_W-1:0]   fwd_up2_reg;
    logic               byp_reg;

    assign above1 = byp_reg ? fwd_up1_reg : rd_reg[PIX_W-1:0];
    assign above2 = byp_reg ? fwd_up2_reg : rd_reg[2*PIX_W-1:PIX_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {above1, wr_pix};
            fwd_up1_reg  <= wr_pix;
            fwd_up2_reg  <= above1;
        end
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    // the memory read returns old data when the same entry is written on that edge, so the write is forwarded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byp_reg <= 1'b0;
        else if (rd_en)
            byp_reg <= wr_en && (wr_addr == rd_addr);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gb3_filter.sv -----
// Window stage and weighted sum with the output register.
// Depends on gb3_pkg and gb3_stream_if.
`default_nettype none
`include "gaussian_blur_3x3_core_defines.svh"

module gb3_filter #(
    parameter int MAX_WIDTH = gb3_pkg::DEF_MAX_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            acc_en,
    input  logic [gb3_pkg::PIX_W-1:0]       acc_pix,
    input  logic [$clog2(MAX_WIDTH)-1:0]    acc_addr,
    input  gb3_pkg::gb3_flags_t             acc_flags,
    input  logic [gb3_pkg::PIX_W-1:0]       above1,
    input  logic [gb3_pkg::PIX_W-1:0]       above2,
    output logic                            free,
    output logic                            wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
    output logic [gb3_pkg::PIX_W-1:0]       wr_pix,
    gb3_pix_out_if.source                   dst
);
    import gb3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic             b_valid_reg;
    logic [PIX_W-1:0] b_pix_reg;
    logic [AW-1:0]    b_addr_reg;
    gb3_flags_t       b_flags_reg;
    logic             b_go;
    logic             o_free;

    logic [PIX_W-1:0] win_reg  [WIN_TAPS];
    logic [PIX_W-1:0] win_next [WIN_TAPS];
    logic [PIX_W-1:0] p        [WIN_TAPS];
    logic [PIX_W+1:0] corner_sum;
    logic [PIX_W+1:0] edge_sum;
    logic [ACC_W-1:0] acc_sum;

    logic             o_valid_reg;
    logic [PIX_W-1:0] o_pix_reg;
    logic             o_last_reg;

    assign o_free = !o_valid_reg || dst.ready;
    assign b_go   = b_valid_reg && (!b_flags_reg.emit || o_free);
    assign free   = !b_valid_reg || b_go;

    assign wr_en   = b_go;
    assign wr_addr = b_addr_reg;
    assign wr_pix  = b_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (free)
            b_valid_reg <= acc_en;
    end

    always_ff @(posedge clk)
    begin
        if (acc_en)
        begin
            b_pix_reg   <= acc_pix;
            b_addr_reg  <= acc_addr;
            b_flags_reg <= acc_flags;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[3*r]     = win_reg[3*r+1];
            win_next[3*r + 1] = win_reg[3*r+2];
        end
        win_next[2] = above2;
        win_next[5] = above1;
        win_next[8] = b_pix_reg;

        for (int k = 0; k < WIN_TAPS; k++)
            p[k] = win_next[k];
        // neighbors outside the frame read as zero
        if (!b_flags_reg.top)
        begin
            p[0] = '0; p[1] = '0; p[2] = '0;
        end
        if (!b_flags_reg.bot)
        begin
            p[6] = '0; p[7] = '0; p[8] = '0;
        end
        if (!b_flags_reg.lft)
        begin
            p[0] = '0; p[3] = '0; p[6] = '0;
        end
        if (!b_flags_reg.rgt)
        begin
            p[2] = '0; p[5] = '0; p[8] = '0;
        end

        corner_sum = (PIX_W+2)'(p[0]) + (PIX_W+2)'(p[2])
                   + (PIX_W+2)'(p[6]) + (PIX_W+2)'(p[8]);
        edge_sum   = (PIX_W+2)'(p[1]) + (PIX_W+2)'(p[3])
                   + (PIX_W+2)'(p[5]) + (PIX_W+2)'(p[7]);
        acc_sum = ACC_W'(corner_sum) * W_CORNER + ACC_W'(edge_sum) * W_EDGE
                + ACC_W'(p[4]) * W_CENTRE + ROUND_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_TAPS; k++)
                win_reg[k] <= '0;
        end
        else if (b_go)
        begin
            for (int k = 0; k < WIN_TAPS; k++)
                win_reg[k] <= win_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (b_go && b_flags_reg.emit)
            o_valid_reg <= 1'b1;
        else if (dst.ready)
            o_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (b_go && b_flags_reg.emit)
        begin
            o_pix_reg  <= acc_sum[ACC_W-1:ACC_W-PIX_W];
            o_last_reg <= b_flags_reg.last;
        end
    end

    assign dst.valid      = o_valid_reg;
    assign dst.pixel_out  = o_pix_reg;
    assign dst.frame_last = o_last_reg;

    `GB3_ASSERT_NOW(a_flt_rise_src, $rose(o_valid_reg), $past(b_go && b_flags_reg.emit))
    `GB3_ASSERT_NOW(a_flt_silent_moves, b_valid_reg && !b_flags_reg.emit, b_go)

endmodule

`default_nettype wire

// ----- hw/rtl/gaussian_blur_3x3_core.sv -----
// gaussian_blur_3x3_core: 3x3 Gaussian blur (sigma 1, zero border) on a raster
// stream of 8-bit pixels of one color plane. Depends on gb3_pkg, gb3_stream_if,
// gb3_cfg, gb3_pos, gb3_linebuf and gb3_filter.
// pixels_in carries one pixel per beat (mode = flush stands for a zero pixel);
// after the W*H frame pixels, W+1 flush beats push out the last results.
// pixels_out carries the blurred pixel; frame_last marks the frame's final one.
// The result for pixel n leaves once beat n+W+1 has been taken: that beat enters the
// window stage register, and once the output register is free its result is
// registered there and offered on pixels_out.
// Throughput is one beat per clock unless pixels_out stalls: each beat does one read
// and one write of the single two-row line buffer memory and one weighted sum.
// The APB port sets width and height; write them only between beats of no
// pending result. Reset restores 640x480 and the frame origin; the line buffer
// is not cleared, border masking hides its unwritten entries.
// When pixels_out stalls, the result waits in the output register; beats keep
// entering until one that gives a result is held in the window stage, and input
// ready then drops.
`default_nettype none

module gaussian_blur_3x3_core #(
    parameter int MAX_WIDTH  = gb3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gb3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gb3_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [gb3_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gb3_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    gb3_pix_in_if.sink                      pixels_in,
    gb3_pix_out_if.source                   pixels_out
);
    import gb3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [CW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic             accept;
    logic             stage_free;
    logic [PIX_W-1:0] pix_val;
    logic [AW-1:0]    pos_addr;
    gb3_flags_t       pos_flags;
    logic [PIX_W-1:0] above1;
    logic [PIX_W-1:0] above2;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [PIX_W-1:0] wr_pix;

    assign pixels_in.ready = stage_free;
    assign accept  = pixels_in.valid && stage_free;
    assign pix_val = (pixels_in.mode == MODE_FLUSH) ? '0 : pixels_in.pixel_in;

    gb3_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .w_eff   (w_eff),
        .h_eff   (h_eff)
    );

    gb3_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .w_eff  (w_eff),
        .h_eff  (h_eff),
        .addr   (pos_addr),
        .flags  (pos_flags)
    );

    gb3_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (pos_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_pix  (wr_pix),
        .above1  (above1),
        .above2  (above2)
    );

    gb3_filter #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc_en    (accept),
        .acc_pix   (pix_val),
        .acc_addr  (pos_addr),
        .acc_flags (pos_flags),
        .above1    (above1),
        .above2    (above2),
        .free      (stage_free),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_pix    (wr_pix),
        .dst       (pixels_out)
    );

endmodule

`default_nettype wire

// ----- test/tb_gaussian_blur_3x3_core.sv -----
// Testbench for gaussian_blur_3x3_core: random and directed pixel frames, checked
// beat by beat against a behavioral blur predictor with zero border and half-up rounding.
// Depends on gb3_pkg, gb3_stream_if and the core RTL.
`timescale 1ns / 100ps

typedef struct packed {
    logic [gb3_pkg::PIX_W-1:0] pixel;
    logic                      last;
} blurred_t;

class blur_scoreboard;
    localparam int unsigned MAXW = gb3_pkg::DEF_MAX_WIDTH;
    localparam int unsigned MAXH = gb3_pkg::DEF_MAX_HEIGHT;

    logic [gb3_pkg::CFG_W_BITS-1:0] width_reg;
    logic [gb3_pkg::CFG_H_BITS-1:0] height_reg;
    logic [7:0]  near_row [MAXW];   // previous row
    logic [7:0]  far_row  [MAXW];   // row before that
    logic [7:0]  win [9];
    int unsigned col_pos;
    int unsigned row_pos;
    blurred_t    blurred_q [$];
    int unsigned mismatches;

    function new();
        width_reg  = gb3_pkg::WIDTH_RESET;
        height_reg = gb3_pkg::HEIGHT_RESET;
        foreach (near_row[i]) near_row[i] = 8'd0;
        foreach (far_row[i]) far_row[i] = 8'd0;
        foreach (win[i]) win[i] = 8'd0;
        col_pos    = 0;
        row_pos    = 0;
        mismatches = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
        if (idx == gb3_pkg::REG_IDX_WIDTH)
            width_reg = value[gb3_pkg::CFG_W_BITS-1:0];
        else
            height_reg = value[gb3_pkg::CFG_H_BITS-1:0];
    endfunction

    function int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAXW) return MAXW;
        return width_reg;
    endfunction

    function int unsigned eff_height();
        if (height_reg == 0) return 1;
        if (height_reg > MAXH) return MAXH;
        return height_reg;
    endfunction

    function bit at_frame_start();
        return col_pos == 0 && row_pos == 0;
    endfunction

    function int unsigned pending();
        return blurred_q.size();
    endfunction

    function void next_row();
        col_pos = 0;
        row_pos = (row_pos + 1) & 32'h1FFF;
    endfunction

    // Advance the window by one accepted beat; queue the blurred pixel it releases.
    function void take_pixel(logic mode, logic [7:0] value);
        int unsigned w, h, j, t, n, r, c, acc, k;
        int unsigned tap [9];
        logic [7:0]  x;
        blurred_t    res;
        w = eff_width();
        h = eff_height();
        x = (mode == gb3_pkg::MODE_FLUSH) ? 8'd0 : value;
        if (col_pos >= w) next_row();
        j = col_pos;
        t = row_pos * w + j;
        for (k = 0; k < 3; k++) begin
            win[k*3]     = win[k*3 + 1];
            win[k*3 + 1] = win[k*3 + 2];
        end
        win[2] = far_row[j];
        win[5] = near_row[j];
        win[8] = x;
        far_row[j]  = near_row[j];
        near_row[j] = x;
        col_pos = j + 1;
        if (col_pos >= w) next_row();
        if (t < w + 1) return;

        n = t - (w + 1);
        r = n / w;
        c = n % w;
        for (k = 0; k < 9; k++) tap[k] = win[k];
        if (r == 0) begin tap[0] = 0; tap[1] = 0; tap[2] = 0; end
        if (r + 1 >= h) begin tap[6] = 0; tap[7] = 0; tap[8] = 0; end
        if (c == 0) begin tap[0] = 0; tap[3] = 0; tap[6] = 0; end
        if (c + 1 >= w) begin tap[2] = 0; tap[5] = 0; tap[8] = 0; end
        acc = gb3_pkg::W_CORNER * (tap[0] + tap[2] + tap[6] + tap[8])
            + gb3_pkg::W_EDGE * (tap[1] + tap[3] + tap[5] + tap[7])
            + gb3_pkg::W_CENTRE * tap[4]
            + gb3_pkg::ROUND_HALF;
        acc = acc >> 16;
        res.pixel = acc[7:0];
        res.last  = (n >= w * h - 1);
        blurred_q = {blurred_q, res};
        if (res.last) begin
            col_pos = 0;
            row_pos = 0;
        end
    endfunction

    function void flag(string what, blurred_t want, logic [7:0] pixel, logic last);
        mismatches++;
        if (mismatches <= 10)
            $display("%t %s: pixel_out exp %0d got %0d, frame_last exp %0b got %0b",
                     $realtime, what, want.pixel, pixel, want.last, last);
    endfunction

    function void check_blurred(logic [7:0] pixel, logic last);
        blurred_t want;
        if (blurred_q.size() == 0) begin
            want = '0;
            flag("unexpected beat", want, pixel, last);
            return;
        end
        want = blurred_q.pop_front();
        if (pixel !== want.pixel || last !== want.last)
            flag("mismatch", want, pixel, last);
    endfunction
endclass

module tb_gaussian_blur_3x3_core;
    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_BEATS = 600;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [gb3_pkg::APB_ADDR_W-1:0] paddr;
    logic [gb3_pkg::APB_DATA_W-1:0] pwdata;
    logic [gb3_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    bit          steady_flow;
    int unsigned beats_sent;
    int unsigned quiet_cycles;
    blur_scoreboard blur_sb;

    gb3_pix_in_if  pix_in_bus ();
    gb3_pix_out_if pix_out_bus ();

    gaussian_blur_3x3_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .pixels_in  (pix_in_bus),
        .pixels_out (pix_out_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic send_pixel(input logic m, input logic [7:0] value);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            pix_in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in_bus.valid    <= 1'b1;
        pix_in_bus.mode     <= m;
        pix_in_bus.pixel_in <= value;
        do @(posedge clk); while (!(pix_in_bus.valid && pix_in_bus.ready));
        blur_sb.take_pixel(m, value);
        beats_sent++;
    endtask

    task automatic drain_results();
        pix_in_bus.valid <= 1'b0;
        while (blur_sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves psel high; the caller closes the transfer
    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        blur_sb.set_register(idx, value);
    endtask

    task automatic resize_frame(input int unsigned w, input int unsigned h);
        drain_results();
        apb_write(gb3_pkg::REG_IDX_WIDTH, w);
        apb_write(gb3_pkg::REG_IDX_HEIGHT, h);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // padding beats until the frame closes; noisy mixes in real pixels
    task automatic pad_frame(input bit noisy);
        while (!blur_sb.at_frame_start())
            send_pixel((noisy && $urandom_range(0, 3) == 0) ? gb3_pkg::MODE_PIXEL
                                                              : gb3_pkg::MODE_FLUSH,
                       8'($urandom_range(0, 255)));
    endtask

    // fill < 0 gives random pixels
    task automatic stream_frame(input int fill, input bit noisy);
        int unsigned i;
        int unsigned count;
        logic        m;
        count = blur_sb.eff_width() * blur_sb.eff_height();
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) == 0) drain_results();
            m = (noisy && $urandom_range(0, 7) == 0) ? gb3_pkg::MODE_FLUSH
                                                      : gb3_pkg::MODE_PIXEL;
            send_pixel(m, (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
        end
        pad_frame(noisy);
    endtask

    initial
    begin : stimulus
        int unsigned w;
        int unsigned h;
        int unsigned k;
        int unsigned start_beats;
        blur_sb = new();
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        pix_in_bus.valid    <= 1'b0;
        pix_in_bus.mode     <= gb3_pkg::MODE_PIXEL;
        pix_in_bus.pixel_in <= '0;
        steady_flow = 1'b0;
        beats_sent  = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // saturated and empty frames
        resize_frame(3, 3);
        stream_frame(255, 1'b0);
        stream_frame(0, 1'b0);

        // flush inside the frame reads as zero; real pixel in the padding replaces it
        resize_frame(3, 2);
        send_pixel(gb3_pkg::MODE_PIXEL, 8'd255);
        send_pixel(gb3_pkg::MODE_FLUSH, 8'd255);
        send_pixel(gb3_pkg::MODE_PIXEL, 8'd1);
        send_pixel(gb3_pkg::MODE_PIXEL, 8'd128);
        send_pixel(gb3_pkg::MODE_FLUSH, 8'h55);
        send_pixel(gb3_pkg::MODE_PIXEL, 8'd0);
        send_pixel(gb3_pkg::MODE_PIXEL, 8'd200);
        pad_frame(1'b0);

        // zero sizes act as 1x1
        resize_frame(0, 0);
        stream_frame(-1, 1'b0);

        // two rows at the widest mid-frame width writes both line stores for
        // every column that later mid-frame resizes can reach
        resize_frame(12, 2);
        stream_frame(-1, 1'b0);

        // width shrunk mid-frame: column past the new width wraps
        resize_frame(8, 2);
        repeat (5) send_pixel(gb3_pkg::MODE_PIXEL, 8'($urandom_range(0, 255)));
        resize_frame(3, 2);
        pad_frame(1'b0);

        // height shrunk once already past the new frame end
        resize_frame(4, 4);
        repeat (12) send_pixel(gb3_pkg::MODE_PIXEL, 8'($urandom_range(0, 255)));
        resize_frame(4, 1);
        pad_frame(1'b0);

        w = 5;
        h = 3;
        resize_frame(w, h);
        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_BEATS)
        begin
            steady_flow = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 0)
            begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                : $urandom_range(1, 12);
                h = $urandom_range(1, 6);
                resize_frame(w, h);
            end
            if ($urandom_range(0, 7) == 0)
            begin
                k = $urandom_range(1, w * h + w);
                repeat (k) send_pixel(gb3_pkg::MODE_PIXEL, 8'($urandom_range(0, 255)));
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 6);
                resize_frame(w, h);
                pad_frame(1'b0);
            end
            else
                stream_frame(-1, $urandom_range(0, 4) == 0);
        end

        steady_flow = 1'b0;
        drain_results();
        if (blur_sb.mismatches == 0 && blur_sb.pending() == 0)
            $display("PASS gaussian_blur_3x3_core");
        else
            $display("FAIL gaussian_blur_3x3_core");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned stall;
        pix_out_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 5);
            if (stall != 0)
            begin
                pix_out_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pix_out_bus.ready <= 1'b1;
            do @(posedge clk); while (!(pix_out_bus.valid && pix_out_bus.ready));
            blur_sb.check_blurred(pix_out_bus.pixel_out, pix_out_bus.frame_last);
        end
    end

    // ends the run if no beat moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (pix_in_bus.valid && pix_in_bus.ready)
                   || (pix_out_bus.valid && pix_out_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL gaussian_blur_3x3_core");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end
endmodule
